[src/bvwq_pkg.sv]
package bvwq_pkg;

	// field widths
	localparam int ADC_BITS   = 12;
	localparam int MV_W       = 18;
	localparam int BK_W       = 15;
	localparam int QUAL_W     = 2;
	localparam int FAULT_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	localparam int DEF_WINDOW_SIZE = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CODE_FILTER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_DEVIATION_MV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HARD_DEVIATION_MV = 2'd2;

	localparam logic [ADC_BITS-1:0] RST_LOW_CODE_FILTER   = 12'd200;
	localparam logic [MV_W-1:0]     RST_SOFT_DEVIATION_MV = 18'd500;
	localparam logic [MV_W-1:0]     RST_HARD_DEVIATION_MV = 18'd3000;

	// quality grades
	localparam logic [QUAL_W-1:0] QUAL_INACCURATE = 2'd0;
	localparam logic [QUAL_W-1:0] QUAL_MOTION     = 2'd1;
	localparam logic [QUAL_W-1:0] QUAL_STATIC     = 2'd2;

	// read fault codes
	localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_MAIN   = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_BACKUP = 2'd2;

	// main: code * 103 / 3, the /3 as multiply by ceil(2^21/3) and shift
	localparam int MAIN_PROD_W  = 19;
	localparam logic [6:0]  MAIN_MUL   = 7'd103;
	localparam logic [19:0] MAIN_RECIP = 20'd699051;
	localparam int MAIN_SHIFT   = 21;

	// backup: code * 133 / 33, the /33 as multiply by ceil(2^25/33) and shift
	localparam int BK_PROD_W    = 20;
	localparam logic [7:0]  BK_MUL     = 8'd133;
	localparam logic [19:0] BK_RECIP   = 20'd1016801;
	localparam int BK_SHIFT     = 25;

	typedef struct packed {
		logic [ADC_BITS-1:0] main_code;
		logic                main_ok;
		logic [ADC_BITS-1:0] backup_code;
		logic                backup_ok;
		logic                accessory_on;
		logic                power_present;
	} bvwq_in_t;

	typedef struct packed {
		logic [MV_W-1:0]    main_mv;
		logic [BK_W-1:0]    backup_mv;
		logic [QUAL_W-1:0]  quality;
		logic               mean_used;
		logic [FAULT_W-1:0] read_fault;
	} bvwq_out_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] low_code_filter;
		logic [MV_W-1:0]     soft_deviation_mv;
		logic [MV_W-1:0]     hard_deviation_mv;
	} bvwq_cfg_t;

	typedef struct packed {
		logic capture;
		logic mul_go;
		logic wr_raw;
		logic sum_clear;
		logic sum_rd;
		logic mean_load;
		logic dev_rd;
		logic out_load;
		logic ring_clear;
	} bvwq_cmd_t;

	typedef struct packed {
		logic main_ok;
		logic backup_ok;
		logic power_present;
	} bvwq_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_WR,
		ST_SUM,
		ST_SUM_DRAIN,
		ST_MEAN,
		ST_DEV,
		ST_DEV_DRAIN,
		ST_OUT
	} bvwq_state_t;

endpackage

[src/bvwq_regs.sv]
module bvwq_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bvwq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bvwq_pkg::CFG_DATA_W-1:0]     cfg_data,
	output bvwq_pkg::bvwq_cfg_t                 cfg
);

	bvwq_pkg::bvwq_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_code_filter   <= bvwq_pkg::RST_LOW_CODE_FILTER;
			cfg_q.soft_deviation_mv <= bvwq_pkg::RST_SOFT_DEVIATION_MV;
			cfg_q.hard_deviation_mv <= bvwq_pkg::RST_HARD_DEVIATION_MV;
		end else if (cfg_valid) begin
			case (cfg_index)
				bvwq_pkg::REG_LOW_CODE_FILTER: begin
					cfg_q.low_code_filter <= cfg_data[bvwq_pkg::ADC_BITS-1:0];
				end
				bvwq_pkg::REG_SOFT_DEVIATION_MV: begin
					cfg_q.soft_deviation_mv <= cfg_data[bvwq_pkg::MV_W-1:0];
				end
				bvwq_pkg::REG_HARD_DEVIATION_MV: begin
					cfg_q.hard_deviation_mv <= cfg_data[bvwq_pkg::MV_W-1:0];
				end
				default: begin
					// unmapped index: write ignored
				end
			endcase
		end
	end

endmodule

[src/bvwq_dp.sv]
module bvwq_dp #(
	parameter int WINDOW_SIZE = bvwq_pkg::DEF_WINDOW_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bvwq_pkg::bvwq_cfg_t               cfg,
	input  bvwq_pkg::bvwq_in_t                in_data,
	input  bvwq_pkg::bvwq_cmd_t               cmd,
	input  logic [$clog2(WINDOW_SIZE)-1:0]    rd_addr,
	output bvwq_pkg::bvwq_sts_t               sts,
	output bvwq_pkg::bvwq_out_t               out_data
);

	localparam int IDX_W   = $clog2(WINDOW_SIZE);
	localparam int SUM_W   = bvwq_pkg::MV_W + IDX_W;
	// mean as sum * ceil(2^K / WINDOW_SIZE) >> K, exact for any sum below 2^SUM_W
	localparam int MEAN_K  = SUM_W + IDX_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam longint MEAN_RECIP_L = ((longint'(1) << MEAN_K) + longint'(WINDOW_SIZE) - 1)
	                                  / longint'(WINDOW_SIZE);
	localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(MEAN_RECIP_L);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_SIZE - 1);

	bvwq_pkg::bvwq_in_t  in_q;
	bvwq_pkg::bvwq_out_t out_q;

	logic [bvwq_pkg::MAIN_PROD_W-1:0] main_prod_q;
	logic [bvwq_pkg::BK_PROD_W-1:0]   bk_prod_q;
	logic [bvwq_pkg::MV_W-1:0]        raw_q;
	logic [bvwq_pkg::BK_W-1:0]        backup_q;
	logic [bvwq_pkg::MV_W-1:0]        mean_q;
	logic [bvwq_pkg::MV_W-1:0]        dev_q;
	logic [SUM_W-1:0]                 num_q;
	logic [IDX_W-1:0]                 wslot_q;

	logic [bvwq_pkg::MV_W-1:0] ring_mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]    vld_q;
	logic [bvwq_pkg::MV_W-1:0] rd_data_s1;
	logic                      rd_vld_s1;
	logic                      sum_rd_s1;
	logic                      dev_rd_s1;

	logic [bvwq_pkg::ADC_BITS-1:0]                 code_f;
	logic [bvwq_pkg::MAIN_PROD_W+19:0]             main_scaled;
	logic [bvwq_pkg::BK_PROD_W+19:0]               bk_scaled;
	logic [bvwq_pkg::MV_W-1:0]                     raw_mv;
	logic [bvwq_pkg::MV_W-1:0]                     rd_val;
	logic [bvwq_pkg::MV_W-1:0]                     abs_d;
	logic [SUM_W+RECIP_W-1:0]                      mean_prod;
	bvwq_pkg::bvwq_out_t                           res;

	assign sts.main_ok       = in_q.main_ok;
	assign sts.backup_ok     = in_q.backup_ok;
	assign sts.power_present = in_q.power_present;
	assign out_data          = out_q;

	// conversion arithmetic
	assign code_f      = (in_q.main_code < cfg.low_code_filter) ? '0 : in_q.main_code;
	assign main_scaled = main_prod_q * bvwq_pkg::MAIN_RECIP;
	assign bk_scaled   = bk_prod_q * bvwq_pkg::BK_RECIP;
	assign raw_mv      = main_scaled[bvwq_pkg::MAIN_SHIFT +: bvwq_pkg::MV_W];

	// window walk arithmetic
	assign rd_val    = rd_vld_s1 ? rd_data_s1 : '0;
	assign abs_d     = (rd_val >= mean_q) ? (rd_val - mean_q) : (mean_q - rd_val);
	assign mean_prod = num_q * MEAN_RECIP;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.mul_go) begin
			main_prod_q <= bvwq_pkg::MAIN_PROD_W'(code_f * bvwq_pkg::MAIN_MUL);
			bk_prod_q   <= bvwq_pkg::BK_PROD_W'(in_q.backup_code * bvwq_pkg::BK_MUL);
		end
		if (cmd.wr_raw) begin
			raw_q    <= raw_mv;
			backup_q <= bk_scaled[bvwq_pkg::BK_SHIFT +: bvwq_pkg::BK_W];
		end
		if (cmd.sum_clear) begin
			num_q <= '0;
		end else if (sum_rd_s1) begin
			num_q <= num_q + SUM_W'(rd_val);
		end
		if (cmd.mean_load) begin
			mean_q <= mean_prod[MEAN_K +: bvwq_pkg::MV_W];
			dev_q  <= '0;
		end else if (dev_rd_s1 && (abs_d > dev_q)) begin
			dev_q <= abs_d;
		end
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	// ring storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_raw) begin
			ring_mem[wslot_q] <= raw_mv;
		end
		rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			wslot_q   <= '0;
			rd_vld_s1 <= 1'b0;
			sum_rd_s1 <= 1'b0;
			dev_rd_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[rd_addr];
			sum_rd_s1 <= cmd.sum_rd;
			dev_rd_s1 <= cmd.dev_rd;
			if (cmd.ring_clear) begin
				vld_q <= '0;
			end else if (cmd.wr_raw) begin
				vld_q[wslot_q] <= 1'b1;
			end
			if (cmd.wr_raw) begin
				wslot_q <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + 1'b1;
			end
		end
	end

	// grading and result assembly
	always_comb begin
		res = '0;
		if (!in_q.main_ok) begin
			res.read_fault = bvwq_pkg::FAULT_MAIN;
		end else begin
			if (dev_q > cfg.hard_deviation_mv) begin
				res.quality   = bvwq_pkg::QUAL_INACCURATE;
				res.mean_used = 1'b0;
			end else if (dev_q > cfg.soft_deviation_mv) begin
				res.quality   = bvwq_pkg::QUAL_INACCURATE;
				res.mean_used = 1'b1;
			end else begin
				res.quality   = in_q.accessory_on ? bvwq_pkg::QUAL_MOTION
				                                  : bvwq_pkg::QUAL_STATIC;
				res.mean_used = 1'b1;
			end
			res.main_mv = res.mean_used ? mean_q : raw_q;
			if (!in_q.backup_ok) begin
				res.backup_mv  = '0;
				res.read_fault = bvwq_pkg::FAULT_BACKUP;
			end else begin
				res.backup_mv  = backup_q;
				res.read_fault = bvwq_pkg::FAULT_NONE;
				if (!in_q.power_present) begin
					res.main_mv = '0;
				end
			end
		end
	end

endmodule

[src/bvwq_ctrl.sv]
module bvwq_ctrl #(
	parameter int WINDOW_SIZE = bvwq_pkg::DEF_WINDOW_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  bvwq_pkg::bvwq_sts_t               sts,
	output bvwq_pkg::bvwq_cmd_t               cmd,
	output logic [$clog2(WINDOW_SIZE)-1:0]    rd_addr
);

	localparam int IDX_W = $clog2(WINDOW_SIZE);
	localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(WINDOW_SIZE - 1);

	bvwq_pkg::bvwq_state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign rd_addr   = cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bvwq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bvwq_pkg::ST_MUL;
				end
			end
			bvwq_pkg::ST_MUL: begin
				state_d = sts.main_ok ? bvwq_pkg::ST_WR : bvwq_pkg::ST_OUT;
			end
			bvwq_pkg::ST_WR: begin
				state_d = bvwq_pkg::ST_SUM;
			end
			bvwq_pkg::ST_SUM: begin
				if (cnt_q == LAST_ENTRY) begin
					state_d = bvwq_pkg::ST_SUM_DRAIN;
				end
			end
			bvwq_pkg::ST_SUM_DRAIN: begin
				state_d = bvwq_pkg::ST_MEAN;
			end
			bvwq_pkg::ST_MEAN: begin
				state_d = bvwq_pkg::ST_DEV;
			end
			bvwq_pkg::ST_DEV: begin
				if (cnt_q == LAST_ENTRY) begin
					state_d = bvwq_pkg::ST_DEV_DRAIN;
				end
			end
			bvwq_pkg::ST_DEV_DRAIN: begin
				state_d = bvwq_pkg::ST_OUT;
			end
			bvwq_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = bvwq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bvwq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bvwq_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			bvwq_pkg::ST_MUL: begin
				cmd.mul_go = 1'b1;
			end
			bvwq_pkg::ST_WR: begin
				cmd.wr_raw    = 1'b1;
				cmd.sum_clear = 1'b1;
			end
			bvwq_pkg::ST_SUM: begin
				cmd.sum_rd = 1'b1;
			end
			bvwq_pkg::ST_MEAN: begin
				cmd.mean_load = 1'b1;
			end
			bvwq_pkg::ST_DEV: begin
				cmd.dev_rd = 1'b1;
			end
			bvwq_pkg::ST_OUT: begin
				cmd.out_load   = out_free;
				// no power, both reads good: window emptied once the item is graded
				cmd.ring_clear = out_free && sts.main_ok && sts.backup_ok
				                 && !sts.power_present;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvwq_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == bvwq_pkg::ST_SUM) || (state_q == bvwq_pkg::ST_DEV)) begin
				cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/battery_voltage_window_qualifier_top.sv]
// Channel  Handshake                Payload
// in       in_valid / in_ready      in_data   (bvwq_in_t)
// out      out_valid / out_ready    out_data  (bvwq_out_t)
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item at a time. A good main read goes from accept to result in two
// passes over the window ring through its single read port; the mean is one
// reciprocal multiply. The next item is taken in the cycle after the result
// is loaded. A failed main read goes from the multiply straight to its
// result. A new item is taken while the last result still waits in the
// output register; a stalled output holds the next result in its final
// state. Reset empties the window at once.
module battery_voltage_window_qualifier_top #(
	parameter int WINDOW_SIZE = bvwq_pkg::DEF_WINDOW_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bvwq_pkg::bvwq_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bvwq_pkg::bvwq_out_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bvwq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bvwq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	bvwq_pkg::bvwq_cfg_t cfg;
	bvwq_pkg::bvwq_cmd_t cmd;
	bvwq_pkg::bvwq_sts_t sts;
	logic [$clog2(WINDOW_SIZE)-1:0] rd_addr;

	bvwq_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bvwq_ctrl #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	bvwq_dp #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_data  (in_data),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
